FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, sampled on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GPF_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gpf assertion failed");

// next-cycle implication
`define GPF_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gpf assertion failed");

`endif

FILE: hw/rtl/gpf_pkg.sv
// ----------------------------------------------------------------------------
// gpf_pkg
// Shared constants for the two-prime sum filter.
// ----------------------------------------------------------------------------
package gpf_pkg;

  localparam int LIMIT_WIDTH = 16;
  localparam int FIRST_PRIME = 2;

endpackage

FILE: hw/rtl/goldbach_pair_filter.sv
// ----------------------------------------------------------------------------
// goldbach_pair_filter
// Flags values that are the sum of two primes, plus a report flag for
// positive values below a configured limit that are not.
//
//   channel | dir | handshake             | word
//   --------+-----+-----------------------+-----------------------------------
//   in      | in  | in_valid_i/in_stall_o | value_i, last_item_i
//   out     | out | out_valid_o/out_stall_i | is_prime_sum_o, report_o, last_out_o
//   cfg     | in  | cfg_we_i              | cfg_wdata_i (upper limit)
//
// One word at a time: the sequencer accepts a word, tests each trial divisor
// of a candidate (bit-serial restoring divider) and ends a test as prime once
// the divisor's square passes it, then loads the result register. Values below
// 4 skip the search. Worst case is set by the candidate-pair search of even values.
// Reset clears the sequencer, the output valid and the limit (to 0).
// A stalled result holds in the output register; in_stall_o is low whenever
// the sequencer is idle, even if that register is still full.
// ----------------------------------------------------------------------------
module goldbach_pair_filter #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [VALUE_WIDTH-1:0]          value_i,
  input  logic                            last_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            is_prime_sum_o,
  output logic                            report_o,
  output logic                            last_out_o,
  input  logic                            cfg_we_i,
  input  logic [gpf_pkg::LIMIT_WIDTH-1:0] cfg_wdata_i
);

  localparam int W     = VALUE_WIDTH;
  localparam int LW    = gpf_pkg::LIMIT_WIDTH;
  localparam int CW    = $clog2(W);
  localparam int CMP_W = ((W > LW) ? W : LW) + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TEST = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]    state_q, state_d;
  logic          out_valid_q, out_valid_d;
  logic [LW-1:0] limit_q, limit_d;

  logic [W-1:0]  val_q, val_d;
  logic          last_q, last_d;
  logic          odd_q, odd_d;
  logic          phase_q, phase_d;
  logic          sum_q, sum_d;
  logic [W-1:0]  i_q, i_d;
  logic [W-1:0]  m_q, m_d;
  logic [W-1:0]  d_q, d_d;
  logic [W:0]    sq_q, sq_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  sh_q, sh_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_sum_q, out_sum_d;
  logic          out_rep_q, out_rep_d;
  logic          out_last_q, out_last_d;

  logic [W:0]    rem_sh;
  logic [W-1:0]  rem_sub;
  logic [W-1:0]  rem_nx;
  logic [W-1:0]  i_inc;
  logic [W-1:0]  half;
  logic          lt4;
  logic          verdict;
  logic          prime;
  logic          pos;
  logic          below;

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign is_prime_sum_o = out_sum_q;
  assign report_o       = out_rep_q;
  assign last_out_o     = out_last_q;

  // restoring divider step, one dividend bit per cycle
  assign rem_sh  = {rem_q, sh_q[W-1]};
  assign rem_sub = rem_sh[W-1:0] - d_q;
  assign rem_nx  = (rem_sh >= {1'b0, d_q}) ? rem_sub : rem_sh[W-1:0];

  assign i_inc = i_q + W'(1);
  assign half  = {1'b0, val_q[W-1:1]};
  assign lt4   = value_i[W-1] || (value_i[W-1:2] == '0);

  assign pos   = !val_q[W-1] && (val_q != '0);
  assign below = $signed({{(CMP_W-W){val_q[W-1]}}, val_q})
               < $signed({{(CMP_W-LW){limit_q[LW-1]}}, limit_q});

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    limit_d     = limit_q;
    val_d       = val_q;
    last_d      = last_q;
    odd_d       = odd_q;
    phase_d     = phase_q;
    sum_d       = sum_q;
    i_d         = i_q;
    m_d         = m_q;
    d_d         = d_q;
    sq_d        = sq_q;
    rem_d       = rem_q;
    sh_d        = sh_q;
    cnt_d       = cnt_q;
    out_sum_d   = out_sum_q;
    out_rep_d   = out_rep_q;
    out_last_d  = out_last_q;
    verdict     = 1'b0;
    prime       = 1'b0;

    if (cfg_we_i) begin
      limit_d = cfg_wdata_i;
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d  = value_i;
          last_d = last_item_i;
          d_d    = W'(gpf_pkg::FIRST_PRIME);
          sq_d   = (W+1)'(gpf_pkg::FIRST_PRIME * gpf_pkg::FIRST_PRIME);
          if (lt4) begin
            sum_d   = 1'b0;
            state_d = S_DONE;
          end else if (value_i[0]) begin
            // odd: only (2, n-2) can work
            odd_d   = 1'b1;
            m_d     = value_i - W'(gpf_pkg::FIRST_PRIME);
            state_d = S_TEST;
          end else begin
            odd_d   = 1'b0;
            phase_d = 1'b0;
            i_d     = W'(gpf_pkg::FIRST_PRIME);
            m_d     = W'(gpf_pkg::FIRST_PRIME);
            state_d = S_TEST;
          end
        end
      end
      S_TEST: begin
        if (sq_q > {1'b0, m_q}) begin
          verdict = 1'b1;
          prime   = 1'b1;
        end else begin
          rem_d   = '0;
          sh_d    = m_q;
          cnt_d   = CW'(W - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = rem_nx;
        sh_d  = sh_q << 1;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          if (rem_nx == '0) begin
            verdict = 1'b1;
            prime   = 1'b0;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            d_d     = d_q + W'(1);
            sq_d    = sq_q + {d_q, 1'b1};
            state_d = S_TEST;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_sum_d   = sum_q;
          out_rep_d   = pos && below && !sum_q;
          out_last_d  = last_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (verdict) begin
      d_d  = W'(gpf_pkg::FIRST_PRIME);
      sq_d = (W+1)'(gpf_pkg::FIRST_PRIME * gpf_pkg::FIRST_PRIME);
      if (odd_q) begin
        sum_d   = prime;
        state_d = S_DONE;
      end else if (!phase_q && prime) begin
        phase_d = 1'b1;
        m_d     = val_q - i_q;
        state_d = S_TEST;
      end else if (phase_q && prime) begin
        sum_d   = 1'b1;
        state_d = S_DONE;
      end else if (i_inc > half) begin
        sum_d   = 1'b0;
        state_d = S_DONE;
      end else begin
        i_d     = i_inc;
        phase_d = 1'b0;
        m_d     = i_inc;
        state_d = S_TEST;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      limit_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      limit_q     <= limit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    last_q     <= last_d;
    odd_q      <= odd_d;
    phase_q    <= phase_d;
    sum_q      <= sum_d;
    i_q        <= i_d;
    m_q        <= m_d;
    d_q        <= d_d;
    sq_q       <= sq_d;
    rem_q      <= rem_d;
    sh_q       <= sh_d;
    cnt_q      <= cnt_d;
    out_sum_q  <= out_sum_d;
    out_rep_q  <= out_rep_d;
    out_last_q <= out_last_d;
  end

endmodule

FILE: hw/rtl/gpf_checker.sv
// ----------------------------------------------------------------------------
// gpf_checker
// Port-level checks on the two-prime sum filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gpf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic is_prime_sum_o,
  input logic report_o,
  input logic last_out_o
);

  logic       out_held;
  logic [2:0] out_word;

  assign out_held = out_valid_o && out_stall_i;
  assign out_word = {is_prime_sum_o, report_o, last_out_o};

  // an accepted word makes the sequencer busy
  `GPF_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // a reported value is never a prime sum
  `GPF_ASSERT_IMPL(a_report_excl, out_valid_o, !(report_o && is_prime_sum_o))

  `GPF_ASSERT_NEXT(a_out_hold, out_held, out_valid_o && $stable(out_word))

endmodule

bind goldbach_pair_filter gpf_checker u_gpf_checker (.*);

FILE: verif/goldbach_pair_filter_tb.sv
// ----------------------------------------------------------------------------
// goldbach_pair_filter_tb
// Self-checking bench for the two-prime sum filter. A queue of values feeds a
// clocked driver, and a monitor predicts the flags of each accepted word and
// checks the result words in order. The run covers directed edge values, then
// random values over several limits, with random idling on both sides and one
// long output hold-off.
// ----------------------------------------------------------------------------
module goldbach_pair_filter_tb;

  localparam int VALUE_WIDTH    = 16;
  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT = 4_000_000;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   last;
  } value_word_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   is_prime_sum;
    logic                   report;
    logic                   last;
  } flags_word_t;

  logic                            clk_i        = 1'b0;
  logic                            rst_ni       = 1'b0;
  logic                            in_valid_i   = 1'b0;
  logic                            in_stall_o;
  logic [VALUE_WIDTH-1:0]          value_i      = '0;
  logic                            last_item_i  = 1'b0;
  logic                            out_valid_o;
  logic                            out_stall_i  = 1'b0;
  logic                            is_prime_sum_o;
  logic                            report_o;
  logic                            last_out_o;
  logic                            cfg_we_i     = 1'b0;
  logic [gpf_pkg::LIMIT_WIDTH-1:0] cfg_wdata_i  = '0;

  value_word_t pending_values[$];
  flags_word_t flags_due[$];
  value_word_t next_word;
  flags_word_t due;

  logic signed [gpf_pkg::LIMIT_WIDTH-1:0] limit_model = '0;
  logic in_taken      = 1'b0;
  int   tx_idle_pct   = 0;
  int   rx_idle_pct   = 0;
  logic hold_request  = 1'b0;
  logic hold_done     = 1'b0;
  int   hold_count    = 0;
  int   quiet_cycles  = 0;
  int   fail_count    = 0;
  int   words_checked = 0;
  int   limits_set    = 0;

  goldbach_pair_filter #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .last_item_i   (last_item_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .is_prime_sum_o(is_prime_sum_o),
    .report_o      (report_o),
    .last_out_o    (last_out_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic bit prime_u(int unsigned m);
    int unsigned d;
    if (m < 2) return 1'b0;
    for (d = 2; d * d <= m; d++) begin
      if (m % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit splits_into_primes(int n);
    int i;
    if (n < 4) return 1'b0;
    // odd: only 2 + (n-2) can work
    if (n % 2 != 0) return prime_u(n - gpf_pkg::FIRST_PRIME);
    for (i = gpf_pkg::FIRST_PRIME; i <= n / 2; i++) begin
      if (prime_u(i) && prime_u(n - i)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic flags_word_t predict_flags(logic [VALUE_WIDTH-1:0] value, logic last);
    flags_word_t f;
    int          n;
    n = int'($signed(value));
    f.value        = value;
    f.is_prime_sum = splits_into_primes(n);
    f.report       = (n > 0) && (n < int'(limit_model)) && !f.is_prime_sum;
    f.last         = last;
    return f;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    fail_count++;
  endtask

  // sender
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (pending_values.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        next_word = pending_values.pop_front();
        in_valid_i  <= 1'b1;
        value_i     <= next_word.value;
        last_item_i <= next_word.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_request && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_count  <= hold_count + 1;
      if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (cfg_we_i) limit_model = $signed(cfg_wdata_i);
      if (in_valid_i && !in_stall_o) begin
        flags_due.push_back(predict_flags(value_i, last_item_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (flags_due.size() == 0) begin
          report_mismatch("result word with no value outstanding");
        end else begin
          due = flags_due.pop_front();
          words_checked++;
          if (is_prime_sum_o !== due.is_prime_sum)
            report_mismatch($sformatf("is_prime_sum %b, want %b, value %0d",
              is_prime_sum_o, due.is_prime_sum, $signed(due.value)));
          if (report_o !== due.report)
            report_mismatch($sformatf("report %b, want %b, value %0d",
              report_o, due.report, $signed(due.value)));
          if (last_out_o !== due.last)
            report_mismatch($sformatf("last_out %b, want %b, value %0d",
              last_out_o, due.last, $signed(due.value)));
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_word(input int value, input bit last);
    value_word_t w;
    w.value = value[VALUE_WIDTH-1:0];
    w.last  = last;
    pending_values.push_back(w);
  endtask

  task automatic wait_drained();
    while (pending_values.size() != 0 || in_valid_i || flags_due.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_limit(input int limit);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= limit[gpf_pkg::LIMIT_WIDTH-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    limits_set++;
  endtask

  function automatic int random_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return $urandom_range(400);
    if (sel < 72) return int'($signed(16'h8000 | 16'($urandom)));
    if (sel < 80) return -int'($urandom_range(64));
    if (sel < 97) return $urandom_range(3000, 401);
    return $urandom_range(32767, 3001);
  endfunction

  task automatic run_random(input int limit, input int tx_pct, input int rx_pct,
                            input int count);
    int k;
    write_limit(limit);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (k = 0; k < count; k++) queue_word(random_value(), $urandom_range(1));
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni      = 1'b1;
    tx_idle_pct = 29;
    rx_idle_pct = 69;

    // reset limit of zero: nothing reported
    queue_word(0, 1'b0);
    queue_word(2, 1'b0);
    queue_word(3, 1'b0);
    queue_word(4, 1'b0);
    queue_word(11, 1'b0);
    queue_word(-1, 1'b1);

    write_limit(32767);
    queue_word(1, 1'b0);
    queue_word(2, 1'b0);
    queue_word(3, 1'b0);
    queue_word(4, 1'b0);
    queue_word(5, 1'b0);
    queue_word(6, 1'b0);
    queue_word(7, 1'b0);
    queue_word(9, 1'b0);
    queue_word(11, 1'b0);
    queue_word(27, 1'b0);
    queue_word(16, 1'b0);
    queue_word(-32768, 1'b0);
    queue_word(-1, 1'b0);
    queue_word(32767, 1'b0);
    queue_word(32766, 1'b0);
    queue_word(32765, 1'b1);

    run_random(-32768, 29, 69, 16);
    run_random(300, 29, 69, 16);
    run_random(1, 69, 29, 16);
    run_random(2, 69, 29, 16);
    run_random($urandom_range(1000, 4), 0, 0, 16);

    // quick words so the result register fills and the input stalls
    wait_drained();
    hold_request = 1'b1;
    queue_word(-7, 1'b0);
    queue_word(0, 1'b0);
    queue_word(2, 1'b0);
    queue_word(-100, 1'b0);
    queue_word(3, 1'b1);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (flags_due.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", flags_due.size()));
    $display("Checked %0d result words over %0d limit settings,", words_checked, limits_set);
    $display("with idling on both sides and a %0d-cycle output hold-off.", HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
